// ===== rtl/n_body_gravity_step_unit_assert.svh =====
// Assertion macros for the gravity step unit.
`ifndef N_BODY_GRAVITY_STEP_UNIT_ASSERT_SVH
`define N_BODY_GRAVITY_STEP_UNIT_ASSERT_SVH

`define NGS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("ngs: forbidden condition");

`define NGS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ngs: implication failed");

`define NGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ngs: next-cycle check failed");

`endif

// ===== rtl/ngs_pkg.sv =====
`timescale 1ns / 1ps
package ngs_pkg;

    localparam int MAX_BODIES_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [31:0] GAIN_RST     = 32'd21474836;
    localparam logic [15:0] PMASS_RST    = 16'd1000;
    localparam logic [15:0] SMASS_RST    = 16'd10000;
    localparam logic [7:0]  PRAD_RST     = 8'd5;
    localparam logic [7:0]  SRAD_RST     = 8'd20;
    localparam logic [15:0] IMM_RST      = 16'd10000;
    localparam logic [31:0] PVX_RST      = 32'd32768;

    localparam logic [2:0] CFG_GAIN   = 3'd0;
    localparam logic [2:0] CFG_PMASS  = 3'd1;
    localparam logic [2:0] CFG_SMASS  = 3'd2;
    localparam logic [2:0] CFG_PRAD   = 3'd3;
    localparam logic [2:0] CFG_SRAD   = 3'd4;
    localparam logic [2:0] CFG_IMM    = 3'd5;
    localparam logic [2:0] CFG_PVX    = 3'd6;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_ADD_PLANET = 2'd1,
        OP_ADD_SUN    = 2'd2,
        OP_CLEAR      = 2'd3
    } t_ngs_op;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_EMPTY = 2'd2
    } t_ngs_kind;

    typedef enum logic [1:0] {
        AOP_MUL  = 2'd0,
        AOP_DIV  = 2'd1,
        AOP_SQRT = 2'd2
    } t_ngs_aop;

    typedef struct packed {
        t_ngs_op            operation;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
    } t_ngs_in;

    typedef struct packed {
        t_ngs_kind          kind;
        logic               status;
        logic [5:0]         body_index;
        logic signed [31:0] body_x;
        logic signed [31:0] body_y;
        logic               immovable;
        logic               last;
    } t_ngs_out;

    typedef struct packed {
        logic        start;
        t_ngs_aop    op;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } t_ngs_req;

    typedef struct packed {
        logic         done;
        logic [127:0] res;
    } t_ngs_rsp;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [15:0]        mass;
        logic [7:0]         radius;
    } t_ngs_body;

    function automatic logic signed [31:0] sat32(input logic [65:0] v);
        logic signed [65:0] s;
        s = $signed(v);
        if (s > 66'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

endpackage

// ===== rtl/ngs_arith.sv =====
`timescale 1ns / 1ps
module ngs_arith (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ngs_pkg::t_ngs_req  i_req,
    output ngs_pkg::t_ngs_rsp  o_rsp
);
    import ngs_pkg::*;

    logic         r_busy;
    logic         r_done;
    logic         r_sat;
    t_ngs_aop     r_op;
    logic [5:0]   r_cnt;
    logic [63:0]  r_a, r_b, r_rem, r_lo, r_q, r_c, r_n;
    logic [127:0] r_acc;
    logic [35:0]  r_srem;
    logic [31:0]  r_root;

    logic [64:0]  w_msum;
    logic [63:0]  w_drem;
    logic         w_dge;
    logic [35:0]  w_srem;
    logic [35:0]  w_trial;
    logic         w_sge;
    logic         w_last;

    assign w_msum  = {1'b0, r_acc[127:64]} + (r_b[0] ? {1'b0, r_a} : 65'd0);
    assign w_drem  = {r_rem[62:0], r_lo[63]};
    assign w_dge   = r_rem[63] | (w_drem >= r_c);
    assign w_srem  = {r_srem[33:0], r_n[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sge   = w_srem >= w_trial;
    assign w_last  = (r_op == AOP_SQRT) ? (r_cnt == 6'd31) : (r_cnt == 6'd63);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (w_last || (r_op == AOP_DIV && r_sat)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_a    <= i_req.a;
            r_b    <= i_req.b;
            r_acc  <= '0;
            r_rem  <= i_req.a;
            r_lo   <= i_req.b;
            r_c    <= i_req.c;
            r_q    <= '0;
            r_sat  <= i_req.a >= i_req.c;
            r_n    <= i_req.a;
            r_srem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            unique case (r_op)
                AOP_MUL: begin
                    r_acc <= {w_msum, r_acc[63:1]};
                    r_b   <= r_b >> 1;
                end
                AOP_DIV: begin
                    if (r_sat) begin
                        r_q <= '1;
                    end else begin
                        r_lo <= r_lo << 1;
                        if (w_dge) begin
                            r_rem <= w_drem - r_c;
                            r_q   <= {r_q[62:0], 1'b1};
                        end else begin
                            r_rem <= w_drem;
                            r_q   <= {r_q[62:0], 1'b0};
                        end
                    end
                end
                AOP_SQRT: begin
                    r_n <= r_n << 2;
                    if (w_sge) begin
                        r_srem <= w_srem - w_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_srem <= w_srem;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        case (r_op)
            AOP_MUL:  o_rsp.res = r_acc;
            AOP_DIV:  o_rsp.res = {64'd0, r_q};
            default:  o_rsp.res = {96'd0, r_root};
        endcase
    end

endmodule

// ===== rtl/n_body_gravity_step_unit.sv =====
`timescale 1ns / 1ps
// channel   ports                               transfer
// input     start, busy, i_item                 start high while busy low
// result    o_valid, o_result                   one cycle per result, no hold-off
// config    i_cfg_we, i_cfg_idx, i_cfg_data     i_cfg_we high
//
// Add and clear: result in the cycle after the transfer; busy stays low.
// Tick: per body pair when both kicks run on the shared unit: nine 64-step
//   multiplies and divides, a root, and a table read and select; a saturating divide
//   ends early. Each body visit also passes LOADI, WAITI and ENDI, each entry shifted
//   on removal ERD and EWR, and each report RREAD and RWAIT.
// Reset clears the body count, state, valid flag and config registers; table contents stay undefined.
// Results cannot be stalled.
module n_body_gravity_step_unit #(
    parameter int MAX_BODIES = ngs_pkg::MAX_BODIES_DEF,
    parameter int FRAC_BITS  = ngs_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ngs_pkg::t_ngs_in  i_item,
    output logic              o_valid,
    output ngs_pkg::t_ngs_out o_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);
    import ngs_pkg::*;

    localparam int CW = $clog2(MAX_BODIES + 1);
    localparam int IW = $clog2(MAX_BODIES);

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_LOADI = 18'h00002,
        S_WAITI = 18'h00004,
        S_READJ = 18'h00008,
        S_WAITJ = 18'h00010,
        S_SQX   = 18'h00020,
        S_SQY   = 18'h00040,
        S_SQRT  = 18'h00080,
        S_GM    = 18'h00100,
        S_KMAG  = 18'h00200,
        S_KMUL  = 18'h00400,
        S_KDIV1 = 18'h00800,
        S_KDIV2 = 18'h01000,
        S_ENDI  = 18'h02000,
        S_ERD   = 18'h04000,
        S_EWR   = 18'h08000,
        S_RREAD = 18'h10000,
        S_RWAIT = 18'h20000
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count, r_i, r_j, r_k;
    logic [31:0]        r_gain, r_pvx;
    logic [15:0]        r_pmass, r_smass, r_imm;
    logic [7:0]         r_prad, r_srad;
    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic [15:0]        r_mass, r_jm;
    logic [7:0]         r_rad, r_jr;
    logic               r_fell, r_comp;
    logic signed [32:0] r_dx, r_dy;
    logic [63:0]        r_sx, r_d2, r_d, r_gm;
    t_ngs_body          r_mem [MAX_BODIES];
    t_ngs_body          r_rd;
    logic               r_valid;
    t_ngs_out           r_out;

    t_ngs_req           w_req;
    t_ngs_rsp           w_rsp;
    logic [IW-1:0]      w_rd_idx;
    logic               w_we;
    logic [IW-1:0]      w_wr_idx;
    t_ngs_body          w_wr;
    logic signed [32:0] w_dx, w_dy;
    logic [32:0]        w_adx, w_ady, w_mag;
    logic [64:0]        w_sum;
    logic [63:0]        w_d2, w_rr, w_q;
    logic [127:0]       w_num;
    logic [30:0]        w_w31;
    logic               w_neg;
    logic signed [31:0] w_vel, w_newv;
    logic [CW-1:0]      w_kp1;
    logic               w_full;

    ngs_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    assign w_dx  = {r_rd.px[31], r_rd.px} - {r_px[31], r_px};
    assign w_dy  = {r_rd.py[31], r_rd.py} - {r_py[31], r_py};
    assign w_adx = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign w_ady = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign w_mag = r_comp ? w_ady : w_adx;
    assign w_sum = {1'b0, r_sx} + {1'b0, w_rsp.res[63:0]};
    assign w_d2  = w_sum[64] ? '1 : w_sum[63:0];
    assign w_rr  = 64'({8'd0, r_jr} * {8'd0, r_jr}) << (2 * FRAC_BITS);
    assign w_num = {64'd0, w_rsp.res[63:0]} << (2 * FRAC_BITS);
    assign w_q   = w_rsp.res[63:0] >> (32 - FRAC_BITS);
    assign w_w31 = (w_q > 64'h7FFFFFFF) ? 31'h7FFFFFFF : w_q[30:0];
    assign w_neg = r_comp ? r_dy[32] : r_dx[32];
    assign w_vel = r_comp ? r_vy : r_vx;
    assign w_newv = w_neg ? sat32({{34{w_vel[31]}}, w_vel} - {35'd0, w_w31})
                          : sat32({{34{w_vel[31]}}, w_vel} + {35'd0, w_w31});
    assign w_kp1  = r_k + CW'(1);
    assign w_full = r_count >= CW'(MAX_BODIES);

    always_comb begin
        w_req       = '0;
        w_req.op    = AOP_MUL;
        w_rd_idx    = r_j[IW-1:0];
        unique case (r_state)
            S_LOADI: w_rd_idx = r_i[IW-1:0];
            S_ERD:   w_rd_idx = w_kp1[IW-1:0];
            S_RREAD: w_rd_idx = r_k[IW-1:0];
            S_WAITJ: begin
                w_req.start = 1'b1;
                w_req.a     = 64'(w_dx[32] ? 33'(-w_dx) : 33'(w_dx));
                w_req.b     = 64'(w_dx[32] ? 33'(-w_dx) : 33'(w_dx));
            end
            S_SQX: begin
                w_req.start = w_rsp.done;
                w_req.a     = 64'(w_ady);
                w_req.b     = 64'(w_ady);
            end
            S_SQY: begin
                w_req.start = w_rsp.done && (w_d2 > w_rr);
                w_req.op    = AOP_SQRT;
                w_req.a     = w_d2;
            end
            S_SQRT: begin
                w_req.start = w_rsp.done;
                w_req.a     = 64'(r_gain);
                w_req.b     = 64'(r_jm);
            end
            S_KMAG: begin
                w_req.start = (w_mag != 33'd0);
                w_req.a     = r_gm;
                w_req.b     = 64'(w_mag);
            end
            S_KMUL: begin
                w_req.start = w_rsp.done;
                w_req.op    = AOP_DIV;
                w_req.a     = w_rsp.res[127:64];
                w_req.b     = w_rsp.res[63:0];
                w_req.c     = r_d;
            end
            S_KDIV1: begin
                w_req.start = w_rsp.done;
                w_req.op    = AOP_DIV;
                w_req.a     = w_num[127:64];
                w_req.b     = w_num[63:0];
                w_req.c     = r_d2;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_we     = 1'b0;
        w_wr_idx = r_count[IW-1:0];
        w_wr     = r_rd;
        unique case (r_state)
            S_IDLE: begin
                w_we          = start && !w_full && (i_item.operation == OP_ADD_PLANET
                                || i_item.operation == OP_ADD_SUN);
                w_wr.px       = sat32(66'({{50{i_item.new_x[15]}}, i_item.new_x}) << FRAC_BITS);
                w_wr.py       = sat32(66'({{50{i_item.new_y[15]}}, i_item.new_y}) << FRAC_BITS);
                w_wr.vy       = '0;
                if (i_item.operation == OP_ADD_PLANET) begin
                    w_wr.vx     = r_pvx;
                    w_wr.mass   = r_pmass;
                    w_wr.radius = r_prad;
                end else begin
                    w_wr.vx     = '0;
                    w_wr.mass   = r_smass;
                    w_wr.radius = r_srad;
                end
            end
            S_ENDI: begin
                w_we        = !r_fell;
                w_wr_idx    = r_i[IW-1:0];
                w_wr.px     = sat32({{34{r_px[31]}}, r_px} + {{34{r_vx[31]}}, r_vx});
                w_wr.py     = sat32({{34{r_py[31]}}, r_py} + {{34{r_vy[31]}}, r_vy});
                w_wr.vx     = r_vx;
                w_wr.vy     = r_vy;
                w_wr.mass   = r_mass;
                w_wr.radius = r_rad;
            end
            S_EWR: begin
                w_we     = 1'b1;
                w_wr_idx = r_k[IW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_idx] <= w_wr;
        end
        r_rd <= r_mem[w_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_gain  <= GAIN_RST;
            r_pmass <= PMASS_RST;
            r_smass <= SMASS_RST;
            r_prad  <= PRAD_RST;
            r_srad  <= SRAD_RST;
            r_imm   <= IMM_RST;
            r_pvx   <= PVX_RST;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAIN:  r_gain  <= i_cfg_data;
                    CFG_PMASS: r_pmass <= i_cfg_data[15:0];
                    CFG_SMASS: r_smass <= i_cfg_data[15:0];
                    CFG_PRAD:  r_prad  <= i_cfg_data[7:0];
                    CFG_SRAD:  r_srad  <= i_cfg_data[7:0];
                    CFG_IMM:   r_imm   <= i_cfg_data[15:0];
                    CFG_PVX:   r_pvx   <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_item.operation == OP_TICK) begin
                            r_state <= S_LOADI;
                        end else begin
                            r_valid <= 1'b1;
                            if (i_item.operation == OP_CLEAR) begin
                                r_count <= '0;
                            end else if (!w_full) begin
                                r_count <= r_count + CW'(1);
                            end
                        end
                    end
                end
                S_LOADI: r_state <= (r_i == r_count) ? S_RREAD : S_WAITI;
                S_WAITI: r_state <= (r_rd.mass < r_imm) ? S_READJ : S_ENDI;
                S_READJ: begin
                    if (r_j == r_count) begin
                        r_state <= S_ENDI;
                    end else if (r_j != r_i) begin
                        r_state <= S_WAITJ;
                    end
                end
                S_WAITJ: r_state <= S_SQX;
                S_SQX: if (w_rsp.done) r_state <= S_SQY;
                S_SQY: if (w_rsp.done) r_state <= (w_d2 > w_rr) ? S_SQRT : S_READJ;
                S_SQRT: if (w_rsp.done) r_state <= S_GM;
                S_GM: if (w_rsp.done) r_state <= S_KMAG;
                S_KMAG: begin
                    if (w_mag != 33'd0) begin
                        r_state <= S_KMUL;
                    end else if (r_comp) begin
                        r_state <= S_READJ;
                    end
                end
                S_KMUL: if (w_rsp.done) r_state <= S_KDIV1;
                S_KDIV1: if (w_rsp.done) r_state <= S_KDIV2;
                S_KDIV2: if (w_rsp.done) r_state <= r_comp ? S_READJ : S_KMAG;
                S_ENDI: r_state <= r_fell ? S_ERD : S_LOADI;
                S_ERD: begin
                    if (w_kp1 >= r_count) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_LOADI;
                    end else begin
                        r_state <= S_EWR;
                    end
                end
                S_EWR: r_state <= S_ERD;
                S_RREAD: begin
                    if (r_count == '0) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RWAIT;
                    end
                end
                S_RWAIT: begin
                    r_valid <= 1'b1;
                    r_state <= (w_kp1 == r_count) ? S_IDLE : S_RREAD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_i                <= '0;
                r_out              <= '0;
                r_out.kind         <= KIND_ACK;
                r_out.last         <= 1'b1;
                r_out.status       <= w_full && i_item.operation != OP_CLEAR;
            end
            S_LOADI: r_k <= '0;
            S_WAITI: begin
                r_px   <= r_rd.px;
                r_py   <= r_rd.py;
                r_vx   <= r_rd.vx;
                r_vy   <= r_rd.vy;
                r_mass <= r_rd.mass;
                r_rad  <= r_rd.radius;
                r_fell <= 1'b0;
                r_j    <= '0;
            end
            S_READJ: if (r_j == r_i && r_j != r_count) r_j <= r_j + CW'(1);
            S_WAITJ: begin
                r_dx <= w_dx;
                r_dy <= w_dy;
                r_jm <= r_rd.mass;
                r_jr <= r_rd.radius;
            end
            S_SQX: if (w_rsp.done) r_sx <= w_rsp.res[63:0];
            S_SQY: begin
                if (w_rsp.done) begin
                    r_d2 <= w_d2;
                    if (!(w_d2 > w_rr)) begin
                        r_fell <= 1'b1;
                        r_j    <= r_j + CW'(1);
                    end
                end
            end
            S_SQRT: if (w_rsp.done) r_d <= w_rsp.res[63:0];
            S_GM: begin
                if (w_rsp.done) begin
                    r_gm   <= w_rsp.res[63:0];
                    r_comp <= 1'b0;
                end
            end
            S_KMAG: begin
                if (w_mag == 33'd0) begin
                    if (r_comp) begin
                        r_j <= r_j + CW'(1);
                    end
                    r_comp <= 1'b1;
                end
            end
            S_KDIV2: begin
                if (w_rsp.done) begin
                    if (r_comp) begin
                        r_vy <= w_newv;
                        r_j  <= r_j + CW'(1);
                    end else begin
                        r_vx <= w_newv;
                    end
                    r_comp <= 1'b1;
                end
            end
            S_ENDI: begin
                r_k <= r_i;
                if (!r_fell) begin
                    r_i <= r_i + CW'(1);
                end
            end
            S_EWR: r_k <= w_kp1;
            S_RREAD: begin
                r_out      <= '0;
                r_out.kind <= KIND_EMPTY;
                r_out.last <= 1'b1;
            end
            S_RWAIT: begin
                r_out.kind       <= KIND_BODY;
                r_out.status     <= 1'b0;
                r_out.body_index <= 6'(r_k);
                r_out.body_x     <= r_rd.px;
                r_out.body_y     <= r_rd.py;
                r_out.immovable  <= r_rd.mass >= r_imm;
                r_out.last       <= w_kp1 == r_count;
                r_k              <= w_kp1;
            end
            default: ;
        endcase
    end

    `include "n_body_gravity_step_unit_assert.svh"

    `NGS_ASSERT_NEVER(a_count_max, i_clk, i_rst_n, r_count > CW'(MAX_BODIES))
    `NGS_ASSERT_NEXT(a_ack_next, i_clk, i_rst_n, start && !busy && i_item.operation != OP_TICK, o_valid && o_result.last)
    `NGS_ASSERT_IMPLY(a_visit_bound, i_clk, i_rst_n, r_state != S_IDLE, r_i <= r_count)

endmodule
